[rtl/kvlp_pkg.sv]
// ============================================================================
// kvlp_pkg
// Shared constants and controller/datapath interface types for the
// key/value line parser.
// ============================================================================
`default_nettype none

package kvlp_pkg;

  // Default store sizes in characters
  localparam int KEY_MAX_DEF   = 32;
  localparam int VALUE_MAX_DEF = 64;

  // Character codes
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;

  // Output word layout
  localparam int CHUNK_W = 64;
  localparam int COUNT_W = 4;
  localparam int OUT_DATA_W = 72;

  // Commands from controller to datapath
  typedef struct packed {
    logic put_key;     // store the input byte as a key character
    logic put_value;   // store the input byte as a value character
    logic clear_line;  // clear both lengths
    logic emit_start;  // begin emission with the first non-empty part
    logic next_part;   // move emission on to the value part
    logic rd_issue;    // read the current chunk from its store
    logic load_out;    // load the current chunk into the output register
    logic idx_inc;     // advance to the next chunk of the part
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_drop;       // carriage return, space or tab
    logic is_nl;
    logic is_hash;
    logic is_eq;
    logic part;          // part under emission: 0 key, 1 value
    logic last_of_part;  // current chunk closes its part
    logic out_free;      // output register can take a word this cycle
  } sts_t;

endpackage

`default_nettype wire

[rtl/kvlp_ram.sv]
// ============================================================================
// kvlp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module kvlp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/kvlp_datapath.sv]
// ============================================================================
// kvlp_datapath
// Character classification, key and value stores, chunk selection and the
// output register of the key/value line parser.
// ============================================================================
`default_nettype none

module kvlp_datapath #(
  parameter int KEY_MAX   = kvlp_pkg::KEY_MAX_DEF,
  parameter int VALUE_MAX = kvlp_pkg::VALUE_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [7:0]                        byte_in,
  input  wire kvlp_pkg::cmd_t                    cmd,
  output kvlp_pkg::sts_t                         sts,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [kvlp_pkg::OUT_DATA_W-1:0]        m_tdata,
  output logic                                   m_tlast,
  output logic                                   m_tuser
);

  import kvlp_pkg::*;

  localparam int KW  = (KEY_MAX + 7) / 8;
  localparam int VW  = (VALUE_MAX + 7) / 8;
  localparam int MW  = (KW > VW) ? KW : VW;
  localparam int KAW = (KW > 1) ? $clog2(KW) : 1;
  localparam int VAW = (VW > 1) ? $clog2(VW) : 1;
  localparam int IW  = $clog2(MW + 1);
  localparam int KLW = $clog2(KEY_MAX + 1);
  localparam int VLW = $clog2(VALUE_MAX + 1);

  logic [KLW-1:0]     key_len;
  logic [VLW-1:0]     val_len;
  logic [CHUNK_W-1:0] key_word;
  logic [CHUNK_W-1:0] val_word;
  logic [CHUNK_W-1:0] key_word_next;
  logic [CHUNK_W-1:0] val_word_next;
  logic [CHUNK_W-1:0] key_rd;
  logic [CHUNK_W-1:0] val_rd;
  logic               part;
  logic [IW-1:0]      idx;
  logic [2:0]         key_lane;
  logic [2:0]         val_lane;
  logic               key_put_ok;
  logic               val_put_ok;
  logic [IW-1:0]      nfull;
  logic [IW-1:0]      idx_end;
  logic [2:0]         rem;
  logic               from_ram;
  logic [CHUNK_W-1:0] chunk_sel;
  logic [COUNT_W-1:0] count_sel;

  // Classify the input character
  assign sts.is_drop = (byte_in == CH_CR) || (byte_in == CH_SP) || (byte_in == CH_TAB);
  assign sts.is_nl   = (byte_in == CH_LF);
  assign sts.is_hash = (byte_in == CH_HASH);
  assign sts.is_eq   = (byte_in == CH_EQ);

  // Assemble characters into the open word, clearing it at lane zero
  assign key_lane   = key_len[2:0];
  assign val_lane   = val_len[2:0];
  assign key_put_ok = cmd.put_key && (key_len < KLW'(KEY_MAX));
  assign val_put_ok = cmd.put_value && (val_len < VLW'(VALUE_MAX));

  always_comb begin
    key_word_next = ((key_lane == 3'd0) ? '0 : key_word)
                    | (CHUNK_W'(byte_in) << {key_lane, 3'b000});
    val_word_next = ((val_lane == 3'd0) ? '0 : val_word)
                    | (CHUNK_W'(byte_in) << {val_lane, 3'b000});
  end

  // Hold lengths and open words
  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= '0;
      val_len <= '0;
    end else if (cmd.clear_line) begin
      key_len <= '0;
      val_len <= '0;
    end else begin
      if (key_put_ok) begin
        key_len <= key_len + 1'b1;
      end
      if (val_put_ok) begin
        val_len <= val_len + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (key_put_ok) begin
      key_word <= key_word_next;
    end
    if (val_put_ok) begin
      val_word <= val_word_next;
    end
  end

  // Full words go to the stores
  kvlp_ram #(.WIDTH(CHUNK_W), .DEPTH(KW)) u_key_ram (
    .clk   (clk),
    .we    (key_put_ok && (key_lane == 3'd7)),
    .waddr (KAW'(key_len >> 3)),
    .wdata (key_word_next),
    .re    (cmd.rd_issue && !part),
    .raddr (idx[KAW-1:0]),
    .rdata (key_rd)
  );

  kvlp_ram #(.WIDTH(CHUNK_W), .DEPTH(VW)) u_val_ram (
    .clk   (clk),
    .we    (val_put_ok && (val_lane == 3'd7)),
    .waddr (VAW'(val_len >> 3)),
    .wdata (val_word_next),
    .re    (cmd.rd_issue && part),
    .raddr (idx[VAW-1:0]),
    .rdata (val_rd)
  );

  // Emission position
  always_ff @(posedge clk) begin
    if (rst) begin
      part <= 1'b0;
      idx  <= '0;
    end else if (cmd.emit_start) begin
      part <= (key_len == '0);
      idx  <= '0;
    end else if (cmd.next_part) begin
      part <= 1'b1;
      idx  <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // Work out the current chunk: full words from a store, the tail from
  // the open word, and an empty chunk for an empty value
  always_comb begin
    nfull    = part ? IW'(val_len >> 3) : IW'(key_len >> 3);
    rem      = part ? val_lane : key_lane;
    idx_end  = ((rem != 3'd0) || (nfull == '0)) ? nfull : (nfull - 1'b1);
    from_ram = (idx < nfull);
    if (from_ram) begin
      chunk_sel = part ? val_rd : key_rd;
      count_sel = COUNT_W'(8);
    end else if (rem != 3'd0) begin
      chunk_sel = part ? val_word : key_word;
      count_sel = {1'b0, rem};
    end else begin
      chunk_sel = '0;
      count_sel = '0;
    end
  end

  assign sts.part         = part;
  assign sts.last_of_part = (idx == idx_end);
  assign sts.out_free     = !m_tvalid || m_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {{(OUT_DATA_W - CHUNK_W - COUNT_W){1'b0}}, count_sel, chunk_sel};
      m_tlast <= part && (idx == idx_end);
      m_tuser <= part;
    end
  end

endmodule

`default_nettype wire

[rtl/kvlp_ctrl.sv]
// ============================================================================
// kvlp_ctrl
// Line state machine and chunk emission sequencer of the key/value line
// parser.
// ============================================================================
`default_nettype none

module kvlp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  output kvlp_pkg::cmd_t      cmd,
  input  wire kvlp_pkg::sts_t sts
);

  import kvlp_pkg::*;

  typedef enum logic [5:0] {
    ST_START   = 6'b000001,
    ST_COMMENT = 6'b000010,
    ST_KEY     = 6'b000100,
    ST_VALUE   = 6'b001000,
    ST_RD      = 6'b010000,
    ST_LOAD    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign s_tready = (state == ST_START) || (state == ST_COMMENT)
                    || (state == ST_KEY) || (state == ST_VALUE);
  assign take     = s_tvalid && s_tready && !sts.is_drop;

  // Decide the next state and the datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_START, ST_COMMENT, ST_KEY, ST_VALUE: begin
        if (take) begin
          if (sts.is_nl) begin
            if (state == ST_VALUE) begin
              cmd.emit_start = 1'b1;
              state_next     = ST_RD;
            end else begin
              cmd.clear_line = 1'b1;
              state_next     = ST_START;
            end
          end else begin
            priority if (state == ST_START) begin
              if (sts.is_hash) begin
                state_next = ST_COMMENT;
              end else begin
                cmd.put_key = 1'b1;
                state_next  = ST_KEY;
              end
            end else if (state == ST_KEY) begin
              if (sts.is_eq) begin
                state_next = ST_VALUE;
              end else begin
                cmd.put_key = 1'b1;
              end
            end else if (state == ST_VALUE) begin
              cmd.put_value = 1'b1;
            end else begin
              state_next = ST_COMMENT;
            end
          end
        end
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.last_of_part) begin
            if (!sts.part) begin
              cmd.next_part = 1'b1;
              state_next    = ST_RD;
            end else begin
              cmd.clear_line = 1'b1;
              state_next     = ST_START;
            end
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_RD;
          end
        end
      end
      default: begin
        state_next = ST_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[rtl/key_value_line_parser_unit.sv]
// ============================================================================
// key_value_line_parser_unit
// Parses configuration text a character at a time and emits the key and
// value of each pair as words of up to eight characters.
// ============================================================================
//
//  channel | dir | tdata (low bit up)                 | tuser | tlast
//  s_      | in  | byte_req[7:0]                      | -     | -
//  m_      | out | chunk[63:0], valid_bytes[67:64]    | part  | last
//
//  One text byte is taken per cycle while a line is being parsed.
//  A newline that closes a key/value pair holds s_tready low while the
//  words go out: each word takes a store read, then an output load, as
//  the key and value stores have registered reads, and m_tready can
//  stall the load.
//  Reset is synchronous; the stores need no clearing pass after it.
//
`default_nettype none

module key_value_line_parser_unit #(
  parameter int KEY_MAX   = kvlp_pkg::KEY_MAX_DEF,
  parameter int VALUE_MAX = kvlp_pkg::VALUE_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [7:0]                   s_tdata,   // byte_req[7:0]
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic [kvlp_pkg::OUT_DATA_W-1:0]   m_tdata,   // chunk[63:0], valid_bytes[67:64]
  output logic                              m_tlast,
  output logic                              m_tuser    // part
);

  import kvlp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kvlp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  kvlp_datapath #(
    .KEY_MAX   (KEY_MAX),
    .VALUE_MAX (VALUE_MAX)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .byte_in  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // An empty word only closes an empty value
  a_empty_is_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[67:64] == 4'd0)) |-> (m_tlast && m_tuser))
    else $error("empty word outside the final value word");

  // A word never claims more than eight characters
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[67:64] <= 4'd8))
    else $error("word character count above eight");

  // The final word of a pair is always a value word
  a_last_is_value: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("final word tagged as key");

  // Text is not taken while a pair is being sent out
  a_no_take_on_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !s_tready)
    else $error("input ready during word emission");

endmodule

`default_nettype wire

[test/key_value_line_parser_unit_tb.sv]
// ============================================================================
// key_value_line_parser_unit_tb
// Self-checking bench for the key/value line parser. A short scripted text
// covers blank bytes, comments, empty lines, lines with no '=', a leading
// '=', empty values and the byte extremes. Random lines follow: mostly
// well-formed pairs, some with overlong keys and values, mixed with comment
// lines, broken lines and raw noise. Every output word is checked field by
// field against the scripted words or a behavioural parser kept inside the
// bench, while both stream sides idle and stall at random.
// ============================================================================
`default_nettype none

module key_value_line_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvlp_pkg::*;

  localparam int KEY_MAX      = KEY_MAX_DEF;
  localparam int VALUE_MAX    = VALUE_MAX_DEF;
  localparam int TEXT_BYTES   = 360;     // bytes to offer at least, script included
  localparam int LONG_HOLD    = 400;     // receiver hold-off, in cycles
  localparam int HOLD_AT_WORD = 10;
  localparam int SETTLE       = 40;      // quiet cycles after the last word
  localparam int CYCLE_LIMIT  = 1000000;

  // One output word as seen on the master side
  typedef struct packed {
    logic        part;
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic        last;
  } word_t;

  // One scripted byte, with the two words it must produce where typed in
  typedef struct {
    logic [7:0] ch;
    bit         typed;
    word_t      key_w;
    word_t      val_w;
  } script_row_t;

  typedef enum logic [1:0] {LINE_START, IN_COMMENT, IN_KEY, IN_VALUE} parse_mode_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata  = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;

  // Parser state of the bench
  parse_mode_t pmode = LINE_START;
  logic [7:0]  key_mem [KEY_MAX];
  logic [7:0]  val_mem [VALUE_MAX];
  int          key_len = 0;
  int          val_len = 0;

  word_t       produced [$];   // words caused by the latest byte
  word_t       words_due [$];  // words still to arrive, oldest first
  script_row_t script [$];

  int errors     = 0;
  int bytes_sent = 0;
  int words_seen = 0;
  int cycles     = 0;
  bit calm       = 1'b0;       // no random idling on either side while set

  key_value_line_parser_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_CR || c == CH_SP || c == CH_TAB;
  endfunction

  function automatic word_t mk(input logic p, input logic [63:0] c, input logic [3:0] n,
                               input logic l);
    word_t w;
    w.part = p;
    w.chunk = c;
    w.nbytes = n;
    w.last = l;
    return w;
  endfunction

  // Cut one store into words of up to eight characters
  task automatic pack_part(input bit is_value, input int len);
    int    pos;
    int    n;
    word_t w;
    pos = 0;
    do begin
      n = (len - pos > 8) ? 8 : len - pos;
      w = '0;
      w.part = is_value;
      w.nbytes = 4'(n);
      for (int i = 0; i < n; i++)
        w.chunk[8*i +: 8] = is_value ? val_mem[pos + i] : key_mem[pos + i];
      pos += n;
      w.last = is_value && pos >= len;
      produced.push_back(w);
    end while (pos < len);
  endtask

  task automatic store_key(input logic [7:0] c);
    if (key_len < KEY_MAX) begin
      key_mem[key_len] = c;
      key_len++;
    end
  endtask

  // Advance the parser by one character and collect the words it releases
  task automatic parse_char(input logic [7:0] c);
    produced.delete();
    if (is_blank(c))
      return;
    if (c == CH_LF) begin
      if (pmode == IN_VALUE) begin
        if (key_len > 0)
          pack_part(1'b0, key_len);
        pack_part(1'b1, val_len);
      end
      pmode = LINE_START;
      key_len = 0;
      val_len = 0;
      return;
    end
    case (pmode)
      LINE_START: begin
        if (c == CH_HASH) begin
          pmode = IN_COMMENT;
        end else begin
          store_key(c);
          pmode = IN_KEY;
        end
      end
      IN_KEY: begin
        if (c == CH_EQ)
          pmode = IN_VALUE;
        else
          store_key(c);
      end
      IN_VALUE: begin
        if (val_len < VALUE_MAX) begin
          val_mem[val_len] = c;
          val_len++;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one byte after a random gap, hold it until taken, then queue its words
  task automatic put_byte(input logic [7:0] c, input bit typed, input word_t kw,
                          input word_t vw);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    parse_char(c);
    if (typed) begin
      words_due.push_back(kw);
      words_due.push_back(vw);
    end else begin
      foreach (produced[i])
        words_due.push_back(produced[i]);
    end
    bytes_sent++;
    if (bytes_sent % 40 == 0)
      calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send(input logic [7:0] c);
    put_byte(c, 1'b0, '0, '0);
  endtask

  // Stop offering and wait until every word has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 2))
      0:       return CH_CR;
      1:       return CH_SP;
      default: return CH_TAB;
    endcase
  endfunction

  function automatic logic [7:0] key_char(input bit first);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_LF || c == CH_EQ || is_blank(c) || (first && c == CH_HASH));
    return c;
  endfunction

  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) == 0)
      return CH_EQ;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  // Drop a blank byte in now and then
  task automatic sprinkle();
    if ($urandom_range(0, 7) == 0)
      send(rand_blank());
  endtask

  task automatic send_pair(input int klen, input int vlen);
    for (int i = 0; i < klen; i++) begin
      sprinkle();
      send(key_char(i == 0));
    end
    sprinkle();
    send(CH_EQ);
    for (int i = 0; i < vlen; i++) begin
      sprinkle();
      send(text_char());
    end
    sprinkle();
    send(CH_LF);
  endtask

  task automatic add_row(input logic [7:0] c, input bit typed, input word_t kw,
                         input word_t vw);
    script_row_t r;
    r.ch = c;
    r.typed = typed;
    r.key_w = kw;
    r.val_w = vw;
    script.push_back(r);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      add_row(s[i], 1'b0, '0, '0);
  endtask

  task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // Receiver: random stalls, one long hold-off, and the word check
  initial begin : receiver
    int    hold;
    bit    held;
    word_t got;
    word_t want;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 15);
      if (!held && words_seen >= HOLD_AT_WORD) begin
        hold = LONG_HOLD;
        held = 1'b1;
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = mk(m_tuser, m_tdata[63:0], m_tdata[67:64], m_tlast);
      words_seen++;
      if (words_due.size() == 0) begin
        flag("unexpected word", '0, got.chunk);
      end else begin
        want = words_due.pop_front();
        if (got.part !== want.part)     flag("part", 64'(want.part), 64'(got.part));
        if (got.chunk !== want.chunk)   flag("chunk", want.chunk, got.chunk);
        if (got.nbytes !== want.nbytes) flag("valid_bytes", 64'(want.nbytes), 64'(got.nbytes));
        if (got.last !== want.last)     flag("last", 64'(want.last), 64'(got.last));
      end
    end
  end

  // Sender: scripted text, then random lines
  initial begin : sender
    int line_no;
    int kind;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Scripted text: empty line, comment, plain pair, blanks, leading '=',
    // line with no '=', empty value, zero and all-ones characters
    add_text("\n");
    add_text("#=x\n");
    add_text("a=b");
    add_row(CH_LF, 1'b1, mk(1'b0, 64'h61, 4'd1, 1'b0), mk(1'b1, 64'h62, 4'd1, 1'b1));
    add_text(" \t\r");
    add_text("==");
    add_row(CH_LF, 1'b1, mk(1'b0, 64'h3D, 4'd1, 1'b0), mk(1'b1, 64'h0, 4'd0, 1'b1));
    add_text("k\n");
    add_text("k=");
    add_row(CH_LF, 1'b1, mk(1'b0, 64'h6B, 4'd1, 1'b0), mk(1'b1, 64'h0, 4'd0, 1'b1));
    add_row(8'h00, 1'b0, '0, '0);
    add_row(CH_EQ, 1'b0, '0, '0);
    add_row(8'hFF, 1'b0, '0, '0);
    add_row(CH_LF, 1'b1, mk(1'b0, 64'h00, 4'd1, 1'b0), mk(1'b1, 64'hFF, 4'd1, 1'b1));
    foreach (script[i])
      put_byte(script[i].ch, script[i].typed, script[i].key_w, script[i].val_w);
    drain();

    // Random lines; the first one overruns both stores
    line_no = 0;
    while (bytes_sent < TEXT_BYTES) begin
      kind = $urandom_range(0, 9);
      if (line_no == 0) begin
        send_pair(KEY_MAX + 4, VALUE_MAX + 6);
      end else if (kind <= 5) begin
        send_pair(($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 10),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(50, 72) : $urandom_range(0, 16));
      end else if (kind == 6) begin
        send(CH_HASH);
        repeat ($urandom_range(0, 10)) send(text_char());
        send(CH_LF);
      end else if (kind == 7) begin
        send(key_char(1'b1));
        repeat ($urandom_range(0, 7)) send(key_char(1'b0));
        send(CH_LF);
      end else if (kind == 8) begin
        repeat ($urandom_range(0, 2)) send(rand_blank());
        send(CH_LF);
      end else begin
        repeat ($urandom_range(1, 6)) send(8'($urandom_range(0, 255)));
      end
      // Hold the text back once until the parser has emptied
      if (line_no == 8)
        drain();
      line_no++;
    end
    drain();

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
